### src/array_exchange_sorter_assert.svh
// Assertion macros for the array exchange sorter.
// Used by the top level; relies on the aclk and aresetn names in scope.
`ifndef ARRAY_EXCHANGE_SORTER_ASSERT_SVH
`define ARRAY_EXCHANGE_SORTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define AES_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define AES_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/aes_pkg.sv
// Package for the array exchange sorter: sizes, item structs, cell links and states.
// No dependencies; used by aes_cell and array_exchange_sorter.
package aes_pkg;

    localparam int MAX_ITEMS = 16;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_ITEMS);
    localparam logic [CNT_W-1:0] ONE_COUNT = CNT_W'(1);

    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
    } aes_in_t;

    typedef struct packed {
        logic signed [31:0] value_res;
        logic               last_res;
        logic               overflow;
    } aes_out_t;

    typedef struct packed {
        logic               insert;
        logic               shift;
        logic signed [31:0] in_value;
    } aes_cell_cmd_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               occ;
        logic               lt;
    } aes_cell_link_t;

    typedef enum logic {
        AES_FILL,
        AES_DRAIN
    } aes_state_t;

endpackage

### src/array_exchange_sorter.sv
// Array exchange sorter top level: a chain of insertion cells and the batch controller.
// Depends on aes_pkg, aes_cell and array_exchange_sorter_assert.svh.
//
// The input channel (s_valid, s_ready, s_item) takes one signed element per cycle
// while a batch is being filled. Each element is inserted into a chain of
// MAX_ITEMS cells in sorted position in the cycle it is accepted. The item whose
// last bit is set closes the batch; elements beyond MAX_ITEMS are dropped and
// every result of that batch then carries overflow.
// After the closing item s_ready falls and the chain shifts toward the first cell,
// one element per result, through a single output register on the m_ side.
// The first result goes through the drain state and the output register, then
// one result per cycle while m_ready stays high; last_res marks the final one.
// The shift chain sets the drain rate and the broadcast insertion sets the fill rate.
// When the receiver stalls, the chain holds and the output item stays put.
// A new batch is accepted as soon as the final result has been loaded into the
// output register. Reset (aresetn low, synchronous) empties the chain and
// clears the output valid; no clearing pass is needed.
module array_exchange_sorter import aes_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  aes_in_t  s_item,
    output logic     m_valid,
    input  logic     m_ready,
    output aes_out_t m_item
);

    aes_state_t       state_reg;
    aes_state_t       state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             dropped_reg;
    logic             dropped_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    aes_out_t         m_item_reg;
    aes_out_t         m_item_next;
    logic             accept;
    logic             load;
    aes_cell_cmd_t    cmd;
    aes_cell_link_t   links [MAX_ITEMS];

    localparam aes_cell_link_t EDGE_LINK = '{value: '0, occ: 1'b0, lt: 1'b0};

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
            aes_cell_link_t prev_link;
            aes_cell_link_t next_link;
            if (gi == 0) begin : g_first
                assign prev_link = EDGE_LINK;
            end else begin : g_mid_prev
                assign prev_link = links[gi-1];
            end
            if (gi == MAX_ITEMS - 1) begin : g_last
                assign next_link = EDGE_LINK;
            end else begin : g_mid_next
                assign next_link = links[gi+1];
            end
            aes_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .cmd       (cmd),
                .prev_link (prev_link),
                .next_link (next_link),
                .link      (links[gi])
            );
        end
    endgenerate

    assign s_ready = (state_reg == AES_FILL);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        load         = 1'b0;
        cmd          = '{insert: 1'b0, shift: 1'b0, in_value: s_item.value};
        m_valid_next = m_valid_reg && !m_ready;
        m_item_next  = m_item_reg;
        unique case (state_reg)
            AES_FILL: begin
                if (accept) begin
                    if (count_reg < MAX_COUNT) begin
                        cmd.insert = 1'b1;
                        count_next = count_reg + ONE_COUNT;
                    end else begin
                        dropped_next = 1'b1;
                    end
                    if (s_item.last) begin
                        state_next = AES_DRAIN;
                    end
                end
            end
            AES_DRAIN: begin
                load = !m_valid_reg || m_ready;
                if (load) begin
                    cmd.shift    = 1'b1;
                    count_next   = count_reg - ONE_COUNT;
                    m_valid_next = 1'b1;
                    m_item_next  = '{value_res: links[0].value,
                                     last_res:  (count_reg == ONE_COUNT),
                                     overflow:  dropped_reg};
                    if (count_reg == ONE_COUNT) begin
                        state_next   = AES_FILL;
                        dropped_next = 1'b0;
                    end
                end
            end
            default: begin
                state_next = AES_FILL;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= AES_FILL;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
    end

`include "array_exchange_sorter_assert.svh"

    `AES_ASSERT_NOW(a_drain_nonempty, state_reg == AES_DRAIN, count_reg != '0, "Draining with an empty chain.")
    `AES_ASSERT_NOW(a_head_occupied, load, links[0].occ, "Result loaded from an empty cell.")
    `AES_ASSERT_NEXT(a_close_drains, accept && s_item.last, !s_ready && count_reg != '0, "Closing item did not start the drain.")
    `AES_ASSERT_NEXT(a_last_refills, load && (count_reg == ONE_COUNT), s_ready && !links[0].occ && count_reg == '0, "Chain not empty after the final result.")

endmodule

### src/aes_cell.sv
// One cell of the sorting chain: holds one element and its occupied bit.
// Depends on aes_pkg for the command and neighbor link structs.
module aes_cell import aes_pkg::*; (
    input  logic           aclk,
    input  logic           aresetn,
    input  aes_cell_cmd_t  cmd,
    input  aes_cell_link_t prev_link,
    input  aes_cell_link_t next_link,
    output aes_cell_link_t link
);

    logic signed [31:0] value_reg;
    logic signed [31:0] value_next;
    logic               occ_reg;
    logic               occ_next;
    logic               lt;

    assign lt   = !occ_reg || ($signed(cmd.in_value) < $signed(value_reg));
    assign link = '{value: value_reg, occ: occ_reg, lt: lt};

    always_comb begin
        value_next = value_reg;
        occ_next   = occ_reg;
        priority if (cmd.shift) begin
            value_next = next_link.value;
            occ_next   = next_link.occ;
        end else if (cmd.insert) begin
            priority if (prev_link.lt) begin
                value_next = prev_link.value;
                occ_next   = prev_link.occ;
            end else if (lt) begin
                value_next = cmd.in_value;
                occ_next   = 1'b1;
            end else begin
                value_next = value_reg;
                occ_next   = occ_reg;
            end
        end else begin
            value_next = value_reg;
            occ_next   = occ_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule

### dv/tb_array_exchange_sorter.sv
// Self-checking testbench for array_exchange_sorter: feeds batches of signed elements
// and checks every sorted result against a batch sorter kept inside this module.
// Depends on aes_pkg and the array_exchange_sorter RTL; reads no files.
module tb_array_exchange_sorter;
    import aes_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 200000;
    localparam int RANDOM_ITEMS = 300;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_BLOCKY
    } rx_mode_t;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    aes_in_t  s_item = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    aes_out_t m_item;

    logic signed [31:0] batch_vals[$];
    logic               batch_dropped = 1'b0;
    aes_out_t           sorted_expect_q[$];
    int                 burst_left = 0;
    int                 items_sent = 0;
    int                 error_count = 0;
    int                 cycle_count = 0;

    array_exchange_sorter dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Stores an accepted element and, when it closes the batch, queues the sorted run.
    task automatic store_element(input logic signed [31:0] v, input logic closing);
        logic signed [31:0] t;
        aes_out_t r;
        if (batch_vals.size() < MAX_ITEMS) begin
            batch_vals.push_back(v);
        end else begin
            batch_dropped = 1'b1;
        end
        if (closing) begin
            for (int i = 1; i < batch_vals.size(); i++) begin
                t = batch_vals[i];
                for (int j = i - 1; j >= 0 && batch_vals[j] > t; j--) begin
                    batch_vals[j + 1] = batch_vals[j];
                    batch_vals[j] = t;
                end
            end
            foreach (batch_vals[k]) begin
                r.value_res = batch_vals[k];
                r.last_res  = (k == batch_vals.size() - 1);
                r.overflow  = batch_dropped;
                sorted_expect_q.push_back(r);
            end
            batch_vals.delete();
            batch_dropped = 1'b0;
        end
    endtask

    task automatic send_element(input logic signed [31:0] v, input logic closing);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_item.value <= v;
        s_item.last  <= closing;
        s_valid      <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        store_element(v, closing);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sorted_expect_q.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic signed [31:0] random_element();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1, 2, 3: return $urandom;
            4, 5:       return $signed($urandom_range(0, 8)) - 4;
            6: begin
                case ($urandom_range(0, 3))
                    0:       return VAL_MIN;
                    1:       return VAL_MAX;
                    2:       return 0;
                    default: return -1;
                endcase
            end
            default:    return $signed($urandom_range(0, 2000)) - 1000;
        endcase
    endfunction

    task automatic send_batch(input int len);
        for (int i = 0; i < len; i++) begin
            send_element(random_element(), i == len - 1);
        end
    endtask

    task automatic test_single_element();
        send_element(VAL_MIN, 1'b1);
        send_element(VAL_MAX, 1'b1);
        send_element(0, 1'b1);
    endtask

    // Mixed extremes and duplicates fill the store; the closing item is dropped.
    task automatic test_full_and_overflow();
        logic signed [31:0] vals[17];
        vals = '{VAL_MAX, 0, -1, VAL_MIN, 5, 5, -7, VAL_MAX, VAL_MIN, 1, 2, 3, -2, 0,
                 100, -100, 42};
        foreach (vals[i]) begin
            send_element(vals[i], i == 16);
        end
    endtask

    task automatic test_drain_pause();
        send_batch(MAX_ITEMS);
        send_batch(3);
        wait_drained();
        send_batch(1);
    endtask

    task automatic test_random_batches();
        int len;
        int target;
        logic paused;
        paused = 1'b0;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            case ($urandom_range(0, 9))
                0:       len = 1;
                1, 2:    len = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 6);
                3:       len = MAX_ITEMS;
                default: len = $urandom_range(2, MAX_ITEMS);
            endcase
            send_batch(len);
            if (!paused && items_sent > target - RANDOM_ITEMS / 2) begin
                wait_drained();
                paused = 1'b1;
            end
        end
    endtask

    initial begin : receiver_pattern
        rx_mode_t mode;
        int span;
        int n;
        n = 0;
        forever begin
            mode = rx_mode_t'($urandom_range(0, 3));
            span = $urandom_range(8, 60);
            repeat (span) begin
                @(negedge aclk);
                n++;
                case (mode)
                    RX_ALWAYS: m_ready <= 1'b1;
                    RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                    default:   m_ready <= ((n % 7) < 4);
                endcase
            end
        end
    end

    always @(posedge aclk) begin : check_results
        aes_out_t expd;
        if (aresetn && m_valid && m_ready) begin
            if (sorted_expect_q.size() == 0) begin
                $error("Unexpected result item: value_res %0d, last_res %0b, overflow %0b",
                       m_item.value_res, m_item.last_res, m_item.overflow);
                error_count++;
            end else begin
                expd = sorted_expect_q.pop_front();
                if (m_item.value_res !== expd.value_res) begin
                    $error("value_res mismatch: expected %0d, actual %0d",
                           expd.value_res, m_item.value_res);
                    error_count++;
                end
                if (m_item.last_res !== expd.last_res) begin
                    $error("last_res mismatch: expected %0b, actual %0b",
                           expd.last_res, m_item.last_res);
                    error_count++;
                end
                if (m_item.overflow !== expd.overflow) begin
                    $error("overflow mismatch: expected %0b, actual %0b",
                           expd.overflow, m_item.overflow);
                    error_count++;
                end
            end
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_single_element();
        test_full_and_overflow();
        test_drain_pause();
        test_random_batches();

        wait_drained();
        repeat (2 * MAX_ITEMS + 8) @(posedge aclk);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+src
src/aes_pkg.sv
src/aes_cell.sv
src/array_exchange_sorter.sv
dv/tb_array_exchange_sorter.sv
